/* design/fpca_pkg.sv */
// Package for the flash page chain allocator: opcodes, status codes, page-use codes.
// No dependencies.
package fpca_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_XLATE = 3'd2,
      OP_COUNT = 3'd3,
      OP_NEXT  = 3'd4,
      OP_OWNER = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOSPACE  = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_BADSIZE  = 2'd3
   } status_type;

   localparam logic [1:0] USE_FREE = 2'd0;
   localparam logic [1:0] USE_DATA = 2'd1;

   typedef struct packed {
      logic [1:0] use_code;
      logic       first;
      logic [7:0] link;
   } entry_type;

endpackage

/* design/fpca_table.sv */
// Page table memory: use code, first mark and link per page, one read port
// (registered) and one write port. Valid bits give reset state. Depends on fpca_pkg.
module fpca_table #(
   parameter int TABLE_PAGES = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          rd_addr,
   output fpca_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [7:0]          wr_addr,
   input  fpca_pkg::entry_type wr_data
);
   fpca_pkg::entry_type mem_ff [TABLE_PAGES];
   logic [TABLE_PAGES-1:0] valid_ff;
   fpca_pkg::entry_type rd_raw_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr < 8'(TABLE_PAGES)) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_addr < 8'(TABLE_PAGES)) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en && wr_addr < 8'(TABLE_PAGES)) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= (rd_addr < 8'(TABLE_PAGES)) && valid_ff[rd_addr] &&
                        !(wr_en && wr_addr == rd_addr);
      end
   end

   // Same-address write bypass is not needed: sequencer never reads a page it
   // wrote in the prior cycle without waiting. Invalid entry reads as reset value.
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;
endmodule

/* design/fpca_size_mem.sv */
// File size store, written on allocate, read on translate. Undefined until written.
// No package dependencies.
module fpca_size_mem #(
   parameter int TABLE_PAGES = 255
) (
   input  logic        clock,
   input  logic [7:0]  rd_addr,
   output logic [23:0] rd_data,
   input  logic        wr_en,
   input  logic [7:0]  wr_addr,
   input  logic [23:0] wr_data
);
   logic [23:0] mem_ff [TABLE_PAGES];

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr < 8'(TABLE_PAGES)) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_addr < 8'(TABLE_PAGES)) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

/* design/flash_page_chain_allocator.sv */
// Flash page chain allocator top level: sequencer over the page table.
// Depends on fpca_pkg, fpca_table, fpca_size_mem.
//
//  channel | ports                                   | direction
//  req     | req_valid/req_stall + opcode..start_fresh | in
//  rsp     | rsp_valid/rsp_stall + status..free_count  | out
//  csr     | csr_write_enable/csr_write_data          | in (usable_pages)
//
// One beat at a time; each table read has a registered result, so a page visit is a
// read state (S_RD) then an evaluate state (S_EVAL). Count and next file scan pages.
// Allocate counts free pages, then takes pages, each past the first with a link patch.
// Free walks the links. Translate reads the size, then walks the links. Find owner: a
// scan of up to TABLE_PAGES pages a step, up to TABLE_PAGES steps. Sync reset clears the table at once
// through per-page valid bits. req_stall is high while a beat is in work or waiting.
module flash_page_chain_allocator #(
   parameter int TABLE_PAGES = 255,
   parameter int PAGE_BYTES  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_handle_page,
   input  logic [23:0] req_file_size,
   input  logic [23:0] req_byte_offset,
   input  logic [23:0] req_byte_length,
   input  logic        req_start_fresh,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_result_page,
   output logic [15:0] rsp_page_offset,
   output logic [7:0]  rsp_free_count,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   localparam int SHIFT = $clog2(PAGE_BYTES);
   localparam logic [7:0] LAST = 8'(TABLE_PAGES - 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD    = 9'b000000010,  // address issued, wait for data
      S_EVAL  = 9'b000000100,  // data present
      S_ALLOC = 9'b000001000,  // space check; second pass of allocate starts if it fits
      S_SIZE  = 9'b000010000,  // size read issued
      S_SIZEV = 9'b000100000,
      S_LINK  = 9'b001000000,  // patch previous page link
      S_DONE  = 9'b010000000,
      S_RSP   = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [7:0]  h_ff, h_in;
   logic [23:0] fsize_ff, fsize_in, off_ff, off_in, len_ff, len_in;
   logic [7:0]  usable_ff;
   logic [7:0]  p_ff, p_in;          // scan index / walk pointer
   logic [7:0]  tgt_ff, tgt_in;      // owner search target
   logic [8:0]  n_ff, n_in;          // step counter
   logic [8:0]  cnt_ff, cnt_in;      // free count or pages taken
   logic [8:0]  need_ff, need_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  first_ff, first_in;
   logic        pass2_ff, pass2_in;
   logic [1:0]  st_ff, st_in;
   logic [7:0]  rp_ff, rp_in;
   logic [15:0] po_ff, po_in;
   logic [7:0]  fc_ff, fc_in;

   logic [7:0]          rd_addr;
   fpca_pkg::entry_type rd_e;
   logic                wr_en;
   logic [7:0]          wr_addr;
   fpca_pkg::entry_type wr_e;
   logic [23:0]         size_q;
   logic                sz_wr;

   fpca_table #(.TABLE_PAGES(TABLE_PAGES)) u_table (
      .clock(clock), .reset(reset), .rd_addr(rd_addr), .rd_data(rd_e),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_e));

   fpca_size_mem #(.TABLE_PAGES(TABLE_PAGES)) u_size (
      .clock(clock), .rd_addr(h_ff), .rd_data(size_q),
      .wr_en(sz_wr), .wr_addr(p_ff), .wr_data(fsize_ff));

   logic [7:0] limit;
   assign limit = (usable_ff > 8'(TABLE_PAGES)) ? 8'(TABLE_PAGES) : usable_ff;

   logic usable_free, is_data, handle_ok, follower;
   assign is_data     = rd_e.use_code == fpca_pkg::USE_DATA;
   assign usable_free = (p_ff < limit) && rd_e.use_code == fpca_pkg::USE_FREE;
   assign handle_ok   = is_data && rd_e.first;
   assign follower    = is_data && !rd_e.first;

   logic [24:0] need_raw, endpos;
   assign need_raw = (25'(fsize_ff) + 25'(PAGE_BYTES - 1)) >> SHIFT;
   assign endpos   = 25'(off_ff) + 25'(len_ff);
   logic [8:0] skip;
   assign skip = 9'(25'(off_ff) >> SHIFT);

   // Walk pointer state for free and translate: p_ff is the page being read.
   always_comb begin
      state_in = state_ff; op_in = op_ff; h_in = h_ff; fsize_in = fsize_ff;
      off_in = off_ff; len_in = len_ff; p_in = p_ff;
      tgt_in = tgt_ff; n_in = n_ff; cnt_in = cnt_ff; need_in = need_ff;
      prev_in = prev_ff; first_in = first_ff; pass2_in = pass2_ff;
      st_in = st_ff; rp_in = rp_ff; po_in = po_ff; fc_in = fc_ff;
      rd_addr = p_ff; wr_en = 1'b0; wr_addr = p_ff; wr_e = '0; sz_wr = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode; h_in = req_handle_page; fsize_in = req_file_size;
               off_in = req_byte_offset; len_in = req_byte_length;
               st_in = fpca_pkg::ST_NOTFOUND; rp_in = '0; po_in = '0; fc_in = '0;
               n_in = '0; cnt_in = '0; pass2_in = 1'b0;
               unique case (req_opcode)
                  fpca_pkg::OP_ALLOC, fpca_pkg::OP_COUNT: begin
                     p_in = '0; state_in = S_RD;
                  end
                  fpca_pkg::OP_FREE, fpca_pkg::OP_XLATE, fpca_pkg::OP_OWNER: begin
                     p_in = req_handle_page;
                     tgt_in = req_handle_page;
                     state_in = (req_handle_page < 8'(TABLE_PAGES)) ? S_RD : S_RSP;
                  end
                  fpca_pkg::OP_NEXT: begin
                     p_in = req_start_fresh ? 8'd0 : req_handle_page + 8'd1;
                     state_in = (req_start_fresh || req_handle_page < LAST) ? S_RD
                                                                            : S_RSP;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            unique case (op_ff)
               fpca_pkg::OP_COUNT: begin
                  if (usable_free) cnt_in = cnt_ff + 9'd1;
                  if (p_ff == LAST) begin
                     st_in = fpca_pkg::ST_OK;
                     fc_in = 8'(usable_free ? cnt_ff + 9'd1 : cnt_ff);
                     state_in = S_RSP;
                  end else begin
                     p_in = p_ff + 8'd1; state_in = S_RD;
                  end
               end
               fpca_pkg::OP_ALLOC: begin
                  if (!pass2_ff) begin
                     if (usable_free) cnt_in = cnt_ff + 9'd1;
                     if (p_ff == LAST) begin
                        // more than 256 pages can never fit, so clamp there
                        if (need_raw == 25'd0) need_in = 9'd1;
                        else if (need_raw > 25'd256) need_in = 9'd256;
                        else need_in = 9'(need_raw);
                        state_in = S_ALLOC;
                     end else begin
                        p_in = p_ff + 8'd1; state_in = S_RD;
                     end
                  end else begin
                     if (usable_free) begin
                        wr_en = 1'b1;
                        wr_e.use_code = fpca_pkg::USE_DATA;
                        wr_e.first = (cnt_ff == 9'd0);
                        wr_e.link = '0;
                        if (cnt_ff == 9'd0) begin
                           sz_wr = 1'b1; first_in = p_ff;
                        end
                        cnt_in = cnt_ff + 9'd1;
                        prev_in = p_ff;
                        tgt_in = p_ff;
                        state_in = (cnt_ff == 9'd0) ? S_DONE : S_LINK;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end
               fpca_pkg::OP_FREE: begin
                  if (n_ff == '0 && !handle_ok) begin
                     state_in = S_RSP;
                  end else if (n_ff != '0 && !(follower && p_ff > prev_ff)) begin
                     st_in = fpca_pkg::ST_OK; rp_in = h_ff; state_in = S_RSP;
                  end else begin
                     wr_en = 1'b1; wr_e = '0;
                     n_in = n_ff + 9'd1; prev_in = p_ff; p_in = rd_e.link;
                     if (rd_e.link == 8'd0 || rd_e.link >= 8'(TABLE_PAGES) ||
                         n_ff == 9'(TABLE_PAGES - 1)) begin
                        st_in = fpca_pkg::ST_OK; rp_in = h_ff; state_in = S_RSP;
                     end else begin
                        state_in = S_RD;
                     end
                  end
               end
               fpca_pkg::OP_XLATE: begin
                  if (n_ff == '0 && !pass2_ff) begin
                     if (!handle_ok) state_in = S_RSP;
                     else state_in = S_SIZE;
                  end else if (n_ff == skip) begin
                     st_in = fpca_pkg::ST_OK; rp_in = p_ff;
                     po_in = 16'(off_ff & 24'(PAGE_BYTES - 1));
                     state_in = S_RSP;
                  end else if (rd_e.link == 8'd0 || rd_e.link >= 8'(TABLE_PAGES)) begin
                     st_in = fpca_pkg::ST_BADSIZE; state_in = S_RSP;
                  end else begin
                     p_in = rd_e.link; n_in = n_ff + 9'd1; state_in = S_RD;
                  end
               end
               fpca_pkg::OP_NEXT: begin
                  if (handle_ok) begin
                     st_in = fpca_pkg::ST_OK; rp_in = p_ff; state_in = S_RSP;
                  end else if (p_ff == LAST) begin
                     state_in = S_RSP;
                  end else begin
                     p_in = p_ff + 8'd1; state_in = S_RD;
                  end
               end
               default: begin  // find owner
                  if (!pass2_ff) begin
                     // reading tgt itself
                     if (!is_data) state_in = S_RSP;
                     else if (rd_e.first) begin
                        st_in = fpca_pkg::ST_OK; rp_in = tgt_ff; state_in = S_RSP;
                     end else if (n_ff >= 9'(TABLE_PAGES) || tgt_ff == 8'd0) begin
                        state_in = S_RSP;
                     end else begin
                        pass2_in = 1'b1; p_in = '0; state_in = S_RD;
                     end
                  end else if (is_data && rd_e.link == tgt_ff) begin
                     tgt_in = p_ff; p_in = p_ff; n_in = n_ff + 9'd1;
                     pass2_in = 1'b0; state_in = S_RD;
                  end else if (p_ff == LAST) begin
                     state_in = S_RSP;
                  end else begin
                     p_in = p_ff + 8'd1; state_in = S_RD;
                  end
               end
            endcase
         end
         S_ALLOC: begin
            if (cnt_ff < need_ff) begin
               st_in = fpca_pkg::ST_NOSPACE; state_in = S_RSP;
            end else begin
               cnt_in = '0; pass2_in = 1'b1; p_in = '0; state_in = S_RD;
            end
         end
         S_LINK: begin
            wr_en = 1'b1; wr_addr = first_ff;  // first_ff holds the page to patch
            wr_e.use_code = fpca_pkg::USE_DATA;
            wr_e.first = (first_ff == rp_ff);
            wr_e.link = tgt_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // after allocate step: advance or finish
            if (cnt_ff == 9'd1 && state_ff == S_DONE) rp_in = first_ff;
            first_in = tgt_ff;
            if (cnt_ff == need_ff) begin
               st_in = fpca_pkg::ST_OK; state_in = S_RSP;
            end else begin
               p_in = p_ff + 8'd1; state_in = S_RD;
            end
         end
         S_SIZE: state_in = S_SIZEV;
         S_SIZEV: begin
            if (25'(size_q) < endpos) begin
               st_in = fpca_pkg::ST_BADSIZE; state_in = S_RSP;
            end else begin
               pass2_in = 1'b1; state_in = S_RD;
            end
         end
         S_RSP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // In S_DONE first_ff becomes the last page taken, the page whose link
   // gets patched next; rp_ff keeps the chain head for the first-mark rewrite.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         usable_ff <= 8'hff;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) usable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; h_ff <= h_in; fsize_ff <= fsize_in; off_ff <= off_in;
      len_ff <= len_in; p_ff <= p_in; tgt_ff <= tgt_in;
      n_ff <= n_in; cnt_ff <= cnt_in; need_ff <= need_in; prev_ff <= prev_in;
      first_ff <= first_in; pass2_ff <= pass2_in; st_ff <= st_in; rp_ff <= rp_in;
      po_ff <= po_in; fc_ff <= fc_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_RSP;
   assign rsp_status      = st_ff;
   assign rsp_result_page = rp_ff;
   assign rsp_page_offset = po_ff;
   assign rsp_free_count  = fc_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("response while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_free_count != 8'd0 |-> rsp_status == fpca_pkg::ST_OK)
      else $error("count with bad status");
endmodule
